>>> rtl/amat_pkg.sv
// shared types and constants for the averaged multiturn angle tracker
`default_nettype none

package amat_pkg;

  // default build values
  localparam int unsigned ANGLE_RANGE_DEF = 16384;
  localparam int unsigned MAX_SAMPLES_DEF = 16;

  // fixed field widths
  localparam int unsigned ANGLE_W  = 14;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned SUM_W    = 22;
  localparam int unsigned CFG_W    = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned STEP_W   = 5;

  // packed stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_AVERAGE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIRECTION    = 4'd1;

  // input item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UNW,
    ST_ADD,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

>>> rtl/averaged_multiturn_angle_tracker_top.sv
// averaged multiturn angle tracker: sample averaging, unwrap and position accumulation
//
// Input stream (s_axis): tuser is the item kind (0 angle sample, 1 position load),
// tdata carries the raw angle and the load value. Output stream (m_axis) carries
// the accumulated position and the averaged angle of the group. A config write
// channel (cfg_valid_i/cfg_ready_o) sets samples per average (index 0) and
// direction inversion (index 1); writes are meant to happen while the block is idle.
// A sample that does not close a group is added to the partial group and gives no result.
// A sample that closes a group starts a bit-serial restoring divide, one quotient
// bit per cycle, then an unwrap step, then a bit-serial add into the 32-bit
// position; the result is registered in ST_OUT once the output register is free,
// and the first, priming group skips the add. The next input transfer is taken
// after ST_OUT returns to ST_IDLE. A load item gives its result the next cycle.
// One item is in work at a time; tready is high only while idle and the output
// register is free or being emptied, so a stalled receiver holds back the input.
// Reset clears position, previous angle, partial group and priming flag, and sets
// samples per average to 1 and inversion off.
`default_nettype none

module averaged_multiturn_angle_tracker_top #(
  parameter int unsigned ANGLE_RANGE = amat_pkg::ANGLE_RANGE_DEF,
  parameter int unsigned MAX_SAMPLES = amat_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // config write channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [amat_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [amat_pkg::CFG_W-1:0]           cfg_data_i,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // tdata: angle_sample [13:0], load_value [45:14], zero [47:46]
  input  wire logic [amat_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: mode [0]
  input  wire logic                                 s_axis_tuser,
  // output stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // tdata: position [31:0], average_angle [45:32], zero [47:46]
  output logic [amat_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DW    = $clog2(ANGLE_RANGE) + 2;
  localparam int unsigned AW    = amat_pkg::ANGLE_W;
  localparam int unsigned PW    = amat_pkg::POS_W;
  localparam int unsigned SW    = amat_pkg::SUM_W;

  amat_pkg::state_e state_q, state_d;

  logic [amat_pkg::CFG_W-1:0] spa_q;
  logic                       inv_q;
  logic [PW-1:0]              pos_q;
  logic [AW-1:0]              prev_q;
  logic [SW-1:0]              sum_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       primed_q;
  logic [amat_pkg::STEP_W-1:0] step_q;
  logic [SW-1:0]              quo_q;
  logic [CNT_W-1:0]           rem_q;
  logic [CNT_W-1:0]           div_q;
  logic [AW-1:0]              avg_q;
  logic [DW-1:0]              chg_q;
  logic                       carry_q;
  logic                       out_valid_q;
  logic [PW-1:0]              out_pos_q;
  logic [AW-1:0]              out_avg_q;

  // input field extraction
  logic             in_mode;
  logic [AW-1:0]    in_angle;
  logic [PW-1:0]    in_load;
  assign in_mode  = s_axis_tuser;
  assign in_angle = s_axis_tdata[AW-1:0];
  assign in_load  = s_axis_tdata[AW+PW-1:AW];

  logic in_acc;
  logic out_free;
  logic out_fill;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // sample saturation and group bookkeeping
  logic [AW-1:0]    sat_angle;
  logic [SW-1:0]    sum_next;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W-1:0] n_clamp;
  logic             group_done;

  always_comb begin
    if (32'(in_angle) >= 32'(ANGLE_RANGE)) begin
      sat_angle = AW'(ANGLE_RANGE - 1);
    end else begin
      sat_angle = in_angle;
    end
    sum_next = sum_q + SW'(sat_angle);
    cnt_next = cnt_q + CNT_W'(1);
    if (spa_q == '0) begin
      n_clamp = CNT_W'(1);
    end else if (32'(spa_q) > 32'(MAX_SAMPLES)) begin
      n_clamp = CNT_W'(MAX_SAMPLES);
    end else begin
      n_clamp = CNT_W'(spa_q);
    end
    group_done = (cnt_next >= n_clamp);
  end

  // restoring divide step, one quotient bit
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_sub;
  logic             q_bit;
  assign rem_sh  = {rem_q, quo_q[SW-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign q_bit   = (rem_sh >= {1'b0, div_q});

  // unwrap against the previous average
  logic [DW-1:0] avg_ext, prev_ext;
  logic [DW-1:0] dir_d, wrp_d, dir_mag, wrp_mag, delta;
  always_comb begin
    avg_ext  = DW'(quo_q[AW-1:0]);
    prev_ext = DW'(prev_q);
    dir_d    = avg_ext - prev_ext;
    if (quo_q[AW-1:0] < prev_q) begin
      wrp_d = dir_d + DW'(ANGLE_RANGE);
    end else begin
      wrp_d = dir_d - DW'(ANGLE_RANGE);
    end
    dir_mag = dir_d[DW-1] ? (~dir_d + DW'(1)) : dir_d;
    wrp_mag = wrp_d[DW-1] ? (~wrp_d + DW'(1)) : wrp_d;
    delta   = (dir_mag >= wrp_mag) ? wrp_d : dir_d;
  end

  // serial add, inversion folded in as complement plus carry-in
  logic chg_bit, sum_bit, carry_d;
  assign chg_bit = chg_q[0] ^ inv_q;
  assign sum_bit = pos_q[0] ^ chg_bit ^ carry_q;
  assign carry_d = (pos_q[0] & chg_bit) | (pos_q[0] & carry_q) | (chg_bit & carry_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      amat_pkg::ST_IDLE: begin
        if (in_acc && (in_mode == amat_pkg::MODE_SAMPLE) && group_done) begin
          state_d = amat_pkg::ST_DIV;
        end
      end
      amat_pkg::ST_DIV: begin
        if (step_q == amat_pkg::STEP_W'(SW - 1)) begin
          state_d = amat_pkg::ST_UNW;
        end
      end
      amat_pkg::ST_UNW: begin
        state_d = primed_q ? amat_pkg::ST_ADD : amat_pkg::ST_OUT;
      end
      amat_pkg::ST_ADD: begin
        if (step_q == amat_pkg::STEP_W'(PW - 1)) begin
          state_d = amat_pkg::ST_OUT;
        end
      end
      amat_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = amat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = amat_pkg::ST_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    out_fill      = 1'b0;
    case (state_q)
      amat_pkg::ST_IDLE: begin
        s_axis_tready = out_free;
      end
      amat_pkg::ST_OUT: begin
        out_fill = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
        out_fill      = 1'b0;
      end
    endcase
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(amat_pkg::OUT_DATA_W - PW - AW){1'b0}}, out_avg_q, out_pos_q};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= amat_pkg::ST_IDLE;
      spa_q       <= amat_pkg::CFG_W'(1);
      inv_q       <= 1'b0;
      pos_q       <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      primed_q    <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // config writes
      if (cfg_valid_i) begin
        if (cfg_index_i == amat_pkg::REG_SAMPLES_PER_AVERAGE) begin
          spa_q <= cfg_data_i;
        end else if (cfg_index_i == amat_pkg::REG_INVERT_DIRECTION) begin
          inv_q <= cfg_data_i[0];
        end
      end
      // output slot
      if (out_fill || (in_acc && (in_mode == amat_pkg::MODE_LOAD))) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        amat_pkg::ST_IDLE: begin
          step_q <= '0;
          if (in_acc) begin
            if (in_mode == amat_pkg::MODE_LOAD) begin
              pos_q <= in_load;
            end else if (group_done) begin
              sum_q <= '0;
              cnt_q <= '0;
            end else begin
              sum_q <= sum_next;
              cnt_q <= cnt_next;
            end
          end
        end
        amat_pkg::ST_DIV: begin
          step_q <= (step_q == amat_pkg::STEP_W'(SW - 1)) ? '0
                                                          : step_q + amat_pkg::STEP_W'(1);
        end
        amat_pkg::ST_UNW: begin
          step_q   <= '0;
          primed_q <= 1'b1;
          prev_q   <= quo_q[AW-1:0];
        end
        amat_pkg::ST_ADD: begin
          step_q <= step_q + amat_pkg::STEP_W'(1);
          pos_q  <= {sum_bit, pos_q[PW-1:1]};
        end
        default: begin
          step_q <= '0;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      amat_pkg::ST_IDLE: begin
        if (in_acc && (in_mode == amat_pkg::MODE_SAMPLE) && group_done) begin
          quo_q <= sum_next;
          rem_q <= '0;
          div_q <= cnt_next;
        end
      end
      amat_pkg::ST_DIV: begin
        quo_q <= {quo_q[SW-2:0], q_bit};
        rem_q <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      end
      amat_pkg::ST_UNW: begin
        avg_q   <= quo_q[AW-1:0];
        chg_q   <= delta;
        carry_q <= inv_q;
      end
      amat_pkg::ST_ADD: begin
        chg_q   <= {chg_q[DW-1], chg_q[DW-1:1]};
        carry_q <= carry_d;
      end
      default: begin
        carry_q <= carry_q;
      end
    endcase
    if (out_fill) begin
      out_pos_q <= pos_q;
      out_avg_q <= avg_q;
    end else if (in_acc && (in_mode == amat_pkg::MODE_LOAD)) begin
      out_pos_q <= in_load;
      out_avg_q <= prev_q;
    end
  end

  // checks
  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == amat_pkg::ST_DIV) |-> (step_q < amat_pkg::STEP_W'(SW)))
    else $error("divide step counter out of range");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == amat_pkg::ST_DIV) |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_group_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_mode == amat_pkg::MODE_SAMPLE) && group_done)
      |=> (state_q == amat_pkg::ST_DIV))
    else $error("completed group did not start the divider");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_pos_q)
      && $stable(out_avg_q)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
